// ===== hdl/mgp_pkg.sv =====
// Shared types and codes for the meshlet greedy packer.
package mgp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_CLOSE    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] REG_VERTEX_LIMIT   = 8'd0;
  localparam logic [7:0] REG_TRIANGLE_LIMIT = 8'd1;
  localparam logic [7:0] REG_VERTEX_TOTAL   = 8'd2;

  // Width used for vertex-limit compares (count + up to three new corners)
  localparam int LIM_W = 9;

  // Control from the sequencer to the vertex table chain
  typedef struct packed {
    logic look;   // register hit flags for the broadcast key
    logic shift;  // push the key into cell 0, every cell takes its neighbor
  } mgp_tbl_ctl_t;

endpackage

// ===== hdl/mgp_cell.sv =====
// One cell of the local vertex table chain.
module mgp_cell import mgp_pkg::*; (
  input  logic         clk,
  input  mgp_tbl_ctl_t ctl,
  input  logic [31:0]  data_in,
  input  logic [31:0]  key,
  input  logic         pos_valid,
  output logic [31:0]  data_out,
  output logic         hit
);

  logic [31:0] entry_r;
  logic        hit_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= data_in;
    end
    if (ctl.look) begin
      hit_r <= pos_valid & (entry_r == key);
    end
  end

  assign data_out = entry_r;
  assign hit      = hit_r;

endmodule

// ===== hdl/mgp_table.sv =====
// Local vertex table: a shifting chain of cells plus hit position encode.
module mgp_table import mgp_pkg::*; #(
  parameter int MAX_VERTS = 64
) (
  input  logic                           clk,
  input  mgp_tbl_ctl_t                   ctl,
  input  logic [31:0]                    key,
  input  logic [$clog2(MAX_VERTS+1)-1:0] count,
  output logic                           found,
  output logic [$clog2(MAX_VERTS)-1:0]   hit_pos
);

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int IW = $clog2(MAX_VERTS);

  logic [31:0]          chain [MAX_VERTS];
  logic [MAX_VERTS-1:0] hits;

  // Cell 0 holds the newest entry; cell p holds entry number count-1-p.
  genvar p;
  generate
    for (p = 0; p < MAX_VERTS; p++) begin : g_cell
      logic [31:0] din;
      if (p == 0) begin : g_head
        assign din = key;
      end else begin : g_body
        assign din = chain[p-1];
      end
      mgp_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .data_in   (din),
        .key       (key),
        .pos_valid (CW'(p) < count),
        .data_out  (chain[p]),
        .hit       (hits[p])
      );
    end
  endgenerate

  // Entries are unique, so at most one hit: OR the positions together.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MAX_VERTS; i++) begin
      if (hits[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
  end

  assign found = |hits;

endmodule

// ===== hdl/meshlet_greedy_packer.sv =====
// Meshlet greedy packer top level: sequencer, counters and output register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready | three corner indices, materials, end
//  out_    | output    | out_valid/out_ready | kind, vertex, locals, close record
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// An item runs from its accept to the next accept through these steps: the
// idle/accept step, a check step, three lookups to count new corners, a
// decision step, three more lookups to place the corners, then the triangle
// and, with a range end, a close. Each lookup goes through the cell chain as
// a look step (key broadcast, registered hit flags), then position encode.
// An error item ends at its check step. Reset is synchronous and clears all control
// state; table contents need no clearing since only cells below the count
// are valid. A stalled output holds the sequencer at its next emit step.
module meshlet_greedy_packer import mgp_pkg::*; #(
  parameter int MAX_VERTS = 64,
  parameter int MAX_TRIS  = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_corner0_index,
  input  logic [31:0] in_corner1_index,
  input  logic [31:0] in_corner2_index,
  input  logic [15:0] in_corner0_material,
  input  logic [15:0] in_corner1_material,
  input  logic [15:0] in_corner2_material,
  input  logic        in_range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_global_vertex,
  output logic [7:0]  out_local0,
  output logic [7:0]  out_local1,
  output logic [7:0]  out_local2,
  output logic [31:0] out_meshlet_vertex_offset,
  output logic [7:0]  out_meshlet_vertex_count,
  output logic [31:0] out_meshlet_triangle_offset,
  output logic [7:0]  out_meshlet_triangle_count,
  output logic [15:0] out_meshlet_material,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int IW = $clog2(MAX_VERTS);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_CNT   = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_PLOOK = 4'd5;
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_TRI   = 4'd7;
  localparam logic [3:0] S_END   = 4'd8;

  // Config
  logic [6:0]  vlimit_r;
  logic [7:0]  tlimit_r;
  logic [31:0] vtotal_r;

  // Control and meshlet state
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    j_r, j_nxt;
  logic [1:0]    add_r, add_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    tris_r, tris_nxt;
  logic [31:0]   vstart_r, vstart_nxt;
  logic [31:0]   tstart_r, tstart_nxt;
  logic [31:0]   emv_r, emv_nxt;
  logic [31:0]   emt_r, emt_nxt;
  logic [15:0]   omat_r, omat_nxt;
  logic          active_r, active_nxt;
  logic          failed_r, failed_nxt;

  // Item payload
  logic [31:0] c_r [3];
  logic [15:0] m_r [3];
  logic        re_r;
  logic [7:0]  loc_r [3];
  logic [7:0]  loc_nxt [3];

  // Output register
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [31:0] ogv_r, ogv_nxt;
  logic [7:0]  ol0_r, ol0_nxt, ol1_r, ol1_nxt, ol2_r, ol2_nxt;
  logic [31:0] ovoff_r, ovoff_nxt, otoff_r, otoff_nxt;
  logic [7:0]  ovcnt_r, ovcnt_nxt, otcnt_r, otcnt_nxt;
  logic [15:0] omatout_r, omatout_nxt;
  logic        olast_r, olast_nxt;

  // Table
  mgp_tbl_ctl_t  tctl;
  logic [31:0]   key;
  logic          found;
  logic [IW-1:0] hit_pos;
  logic [CW-1:0] hit_idx;

  mgp_table #(.MAX_VERTS(MAX_VERTS)) u_table (
    .clk     (clk),
    .ctl     (tctl),
    .key     (key),
    .count   (count_r),
    .found   (found),
    .hit_pos (hit_pos)
  );

  assign key     = c_r[j_r];
  assign hit_idx = count_r - CW'(1) - CW'(hit_pos);

  logic             ofree, accept, bad, need_close;
  logic [LIM_W-1:0] vlim, vsum;
  logic [7:0]       tlim;

  assign ofree  = !ov_r || out_ready;
  assign accept = in_valid && in_ready;
  assign bad    = failed_r || c_r[0] >= vtotal_r || c_r[1] >= vtotal_r ||
                  c_r[2] >= vtotal_r || m_r[1] != m_r[0] || m_r[2] != m_r[0];
  assign vlim   = (LIM_W'(vlimit_r) < LIM_W'(MAX_VERTS)) ? LIM_W'(vlimit_r)
                                                         : LIM_W'(MAX_VERTS);
  assign tlim   = (tlimit_r < 8'(MAX_TRIS)) ? tlimit_r : 8'(MAX_TRIS);
  assign vsum   = LIM_W'(count_r) + LIM_W'(add_r);
  assign need_close = active_r && (m_r[0] != omat_r || vsum > vlim || tris_r >= tlim);

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    add_nxt     = add_r;
    count_nxt   = count_r;
    tris_nxt    = tris_r;
    vstart_nxt  = vstart_r;
    tstart_nxt  = tstart_r;
    emv_nxt     = emv_r;
    emt_nxt     = emt_r;
    omat_nxt    = omat_r;
    active_nxt  = active_r;
    failed_nxt  = failed_r;
    loc_nxt     = loc_r;
    tctl        = '0;
    ov_nxt      = ov_r && !out_ready;
    okind_nxt   = okind_r;
    ogv_nxt     = ogv_r;
    ol0_nxt     = ol0_r;
    ol1_nxt     = ol1_r;
    ol2_nxt     = ol2_r;
    ovoff_nxt   = ovoff_r;
    ovcnt_nxt   = ovcnt_r;
    otoff_nxt   = otoff_r;
    otcnt_nxt   = otcnt_r;
    omatout_nxt = omatout_r;
    olast_nxt   = olast_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (bad) begin
          if (ofree) begin
            ov_nxt = 1'b1; okind_nxt = KIND_ERROR; olast_nxt = 1'b1;
            ogv_nxt = '0; ol0_nxt = '0; ol1_nxt = '0; ol2_nxt = '0;
            ovoff_nxt = '0; ovcnt_nxt = '0; otoff_nxt = '0; otcnt_nxt = '0;
            omatout_nxt = '0;
            failed_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          j_nxt = 2'd0; add_nxt = 2'd0; state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        tctl.look = 1'b1;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (!found) begin
          add_nxt = add_r + 2'd1;
        end
        if (j_r == 2'd2) begin
          state_nxt = S_DEC;
        end else begin
          j_nxt = j_r + 2'd1; state_nxt = S_LOOK;
        end
      end
      S_DEC: begin
        if (!need_close || ofree) begin
          if (need_close) begin
            ov_nxt = 1'b1; okind_nxt = KIND_CLOSE; olast_nxt = 1'b0;
            ogv_nxt = '0; ol0_nxt = '0; ol1_nxt = '0; ol2_nxt = '0;
            ovoff_nxt = vstart_r; ovcnt_nxt = 8'(count_r);
            otoff_nxt = tstart_r; otcnt_nxt = tris_r; omatout_nxt = omat_r;
            count_nxt = '0; tris_nxt = '0;
            vstart_nxt = emv_r; tstart_nxt = emt_r;
          end
          if (!active_r || need_close) begin
            omat_nxt = m_r[0];
          end
          active_nxt = 1'b1;
          j_nxt      = 2'd0;
          state_nxt  = S_PLOOK;
        end
      end
      S_PLOOK: begin
        tctl.look = 1'b1;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        if (found || count_r >= CW'(MAX_VERTS) || ofree) begin
          if (found) begin
            loc_nxt[j_r] = 8'(hit_idx);
          end else if (count_r < CW'(MAX_VERTS)) begin
            // new corner: push into the chain and emit its vertex entry
            tctl.shift   = 1'b1;
            loc_nxt[j_r] = 8'(count_r);
            count_nxt    = count_r + CW'(1);
            emv_nxt      = emv_r + 32'd1;
            ov_nxt = 1'b1; okind_nxt = KIND_VERTEX; olast_nxt = 1'b0;
            ogv_nxt = c_r[j_r]; ol0_nxt = '0; ol1_nxt = '0; ol2_nxt = '0;
            ovoff_nxt = '0; ovcnt_nxt = '0; otoff_nxt = '0; otcnt_nxt = '0;
            omatout_nxt = '0;
          end else begin
            loc_nxt[j_r] = 8'd0;
          end
          if (j_r == 2'd2) begin
            state_nxt = S_TRI;
          end else begin
            j_nxt = j_r + 2'd1; state_nxt = S_PLOOK;
          end
        end
      end
      S_TRI: begin
        if (ofree) begin
          ov_nxt = 1'b1; okind_nxt = KIND_TRIANGLE; olast_nxt = !re_r;
          ogv_nxt = '0; ol0_nxt = loc_r[0]; ol1_nxt = loc_r[1]; ol2_nxt = loc_r[2];
          ovoff_nxt = '0; ovcnt_nxt = '0; otoff_nxt = '0; otcnt_nxt = '0;
          omatout_nxt = '0;
          emt_nxt  = emt_r + 32'd1;
          tris_nxt = tris_r + 8'd1;
          state_nxt = re_r ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (ofree) begin
          ov_nxt = 1'b1; okind_nxt = KIND_CLOSE; olast_nxt = 1'b1;
          ogv_nxt = '0; ol0_nxt = '0; ol1_nxt = '0; ol2_nxt = '0;
          ovoff_nxt = vstart_r; ovcnt_nxt = 8'(count_r);
          otoff_nxt = tstart_r; otcnt_nxt = tris_r; omatout_nxt = omat_r;
          count_nxt = '0; tris_nxt = '0;
          vstart_nxt = emv_r; tstart_nxt = emt_r;
          active_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      j_r      <= '0;
      add_r    <= '0;
      count_r  <= '0;
      tris_r   <= '0;
      vstart_r <= '0;
      tstart_r <= '0;
      emv_r    <= '0;
      emt_r    <= '0;
      omat_r   <= '0;
      active_r <= 1'b0;
      failed_r <= 1'b0;
      ov_r     <= 1'b0;
      vlimit_r <= 7'd64;
      tlimit_r <= 8'd128;
      vtotal_r <= '0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      add_r    <= add_nxt;
      count_r  <= count_nxt;
      tris_r   <= tris_nxt;
      vstart_r <= vstart_nxt;
      tstart_r <= tstart_nxt;
      emv_r    <= emv_nxt;
      emt_r    <= emt_nxt;
      omat_r   <= omat_nxt;
      active_r <= active_nxt;
      failed_r <= failed_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_LIMIT:   vlimit_r <= cfg_wdata[6:0];
          REG_TRIANGLE_LIMIT: tlimit_r <= cfg_wdata[7:0];
          REG_VERTEX_TOTAL:   vtotal_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r[0] <= in_corner0_index;
      c_r[1] <= in_corner1_index;
      c_r[2] <= in_corner2_index;
      m_r[0] <= in_corner0_material;
      m_r[1] <= in_corner1_material;
      m_r[2] <= in_corner2_material;
      re_r   <= in_range_end;
    end
    loc_r     <= loc_nxt;
    okind_r   <= okind_nxt;
    ogv_r     <= ogv_nxt;
    ol0_r     <= ol0_nxt;
    ol1_r     <= ol1_nxt;
    ol2_r     <= ol2_nxt;
    ovoff_r   <= ovoff_nxt;
    ovcnt_r   <= ovcnt_nxt;
    otoff_r   <= otoff_nxt;
    otcnt_r   <= otcnt_nxt;
    omatout_r <= omatout_nxt;
    olast_r   <= olast_nxt;
  end

  assign in_ready                    = (state_r == S_IDLE);
  assign out_valid                   = ov_r;
  assign out_result_kind             = okind_r;
  assign out_global_vertex           = ogv_r;
  assign out_local0                  = ol0_r;
  assign out_local1                  = ol1_r;
  assign out_local2                  = ol2_r;
  assign out_meshlet_vertex_offset   = ovoff_r;
  assign out_meshlet_vertex_count    = ovcnt_r;
  assign out_meshlet_triangle_offset = otoff_r;
  assign out_meshlet_triangle_count  = otcnt_r;
  assign out_meshlet_material        = omatout_r;
  assign out_last                    = olast_r;

endmodule
